// ----- hdl/hstc_pkg.sv -----
`timescale 1ns / 1ps
package hstc_pkg;

  // control point slots held by the two point registers
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;

  // configuration register indexes
  localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [1:0] CFG_POINTS_LOW  = 2'd1;
  localparam logic [1:0] CFG_POINTS_HIGH = 2'd2;

  localparam logic [3:0]  RST_POINT_COUNT = 4'd2;
  localparam logic [63:0] RST_POINTS_LOW  = 64'h0000_0000_FFFF_0000;
  localparam logic [63:0] RST_POINTS_HIGH = 64'h0;

  // where the level sits inside its segment
  typedef enum logic [1:0] {
    ZS_LOW,
    ZS_MID,
    ZS_HIGH
  } zsel_t;

  // one classified item, front to back
  typedef struct packed {
    logic              deg;
    logic [7:0]        yl;
    logic [7:0]        yr;
    logic [7:0]        d;
    logic [7:0]        dxl;
    zsel_t             zsel;
    logic signed [8:0] dy_l;
    logic signed [8:0] dy_lm;
    logic signed [8:0] dx_lm;
    logic signed [8:0] dy_r;
    logic signed [8:0] dx_r;
    logic              l_first;
    logic              r_last;
  } seg_item_t;

endpackage

// ----- hdl/hermite_spline_tone_curve.sv -----
`timescale 1ns / 1ps
// a push transaction reaches the ports through the queue, the back end and the output register;
// a zero-width segment skips the divisions and goes from S_IDLE straight to S_OUT
// the back end takes no new level until it is back in S_IDLE, after four 24-step
// divisions (segment position and three slopes) in the single shared divider of the back end
// a two-entry queue between front and back takes levels while the back end works
// reset (synchronous, rst_n low): queue and output register empty, points (0,0) and (255,255), two in use
module hermite_spline_tone_curve import hstc_pkg::*; #(
  parameter int MAX_POINTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_level_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_level_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration registers
  logic [3:0]  point_count_r;
  logic [63:0] points_low_r, points_high_r;

  seg_item_t front_item, q_item;
  logic      q_empty, q_pop;

  // writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= RST_POINT_COUNT;
      points_low_r  <= RST_POINTS_LOW;
      points_high_r <= RST_POINTS_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POINT_COUNT: point_count_r <= cfg_data[3:0];
        CFG_POINTS_LOW:  points_low_r  <= cfg_data;
        CFG_POINTS_HIGH: points_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: segment search and per-item differences, no state
  hstc_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .point_count (point_count_r),
    .points_low  (points_low_r),
    .points_high (points_high_r),
    .level       (in_level_in),
    .item        (front_item)
  );

  // decoupling queue; a push transaction lands here directly
  hstc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (in_push),
    .wr_item (front_item),
    .full    (in_full),
    .rd      (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  // back: divisions, basis, blend, rounding and saturation, output register
  hstc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_level (out_level_out)
  );

endmodule

// ----- hdl/hstc_front.sv -----
`timescale 1ns / 1ps
module hstc_front import hstc_pkg::*; #(
  parameter int MAX_POINTS = 8
) (
  input  logic [3:0]  point_count,
  input  logic [63:0] points_low,
  input  logic [63:0] points_high,
  input  logic [7:0]  level,
  output seg_item_t   item
);

  logic [7:0]        px [NUM_SLOTS];
  logic [7:0]        py [NUM_SLOTS];
  logic [3:0]        n;
  logic [SLOT_W-1:0] r, l, lm, rp;
  logic signed [8:0] dxx;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (i < 4) begin
        px[i] = points_low[16*i +: 8];
        py[i] = points_low[16*i+8 +: 8];
      end else begin
        px[i] = points_high[16*(i-4) +: 8];
        py[i] = points_high[16*(i-4)+8 +: 8];
      end
    end
  end

  always_comb begin
    if (point_count < 4'd2) n = 4'd2;
    else if (point_count > 4'(MAX_POINTS)) n = 4'(MAX_POINTS);
    else n = point_count;

    // first point from slot 1 on at or above the level, else the last one
    r = SLOT_W'(n - 4'd1);
    for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
      if (4'(i) < n && px[i] >= level) r = SLOT_W'(i);
    end
    l  = r - SLOT_W'(1);
    lm = l - SLOT_W'(1);
    rp = r + SLOT_W'(1);

    dxx = $signed({1'b0, px[r]}) - $signed({1'b0, px[l]});

    item.deg  = (dxx <= 9'sd0);
    item.yl   = py[l];
    item.yr   = py[r];
    item.d    = dxx[7:0];
    item.dxl  = level - px[l];
    if (level <= px[l]) item.zsel = ZS_LOW;
    else if (level >= px[r]) item.zsel = ZS_HIGH;
    else item.zsel = ZS_MID;
    item.dy_l    = $signed({1'b0, py[r]}) - $signed({1'b0, py[l]});
    item.l_first = (l == '0);
    item.r_last  = ({1'b0, r} == n - 4'd1);
    if (item.l_first) begin
      item.dy_lm = '0;
      item.dx_lm = '0;
    end else begin
      item.dy_lm = $signed({1'b0, py[l]}) - $signed({1'b0, py[lm]});
      item.dx_lm = $signed({1'b0, px[l]}) - $signed({1'b0, px[lm]});
    end
    if (item.r_last) begin
      item.dy_r = '0;
      item.dx_r = '0;
    end else begin
      item.dy_r = $signed({1'b0, py[rp]}) - $signed({1'b0, py[r]});
      item.dx_r = $signed({1'b0, px[rp]}) - $signed({1'b0, px[r]});
    end
  end

endmodule

// ----- hdl/hstc_queue.sv -----
`timescale 1ns / 1ps
module hstc_queue import hstc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr,
  input  seg_item_t wr_item,
  output logic      full,
  input  logic      rd,
  output seg_item_t rd_item,
  output logic      empty
);

  seg_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 2'd1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 2'd1;
    end
    if (do_wr) mem_r[wp_r] <= wr_item;
  end

endmodule

// ----- hdl/hstc_back.sv -----
`timescale 1ns / 1ps
module hstc_back import hstc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  seg_item_t q_item,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output logic [7:0] out_level
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DIV, S_SQ, S_CUBE, S_BASIS, S_PROD, S_SUM, S_OUT
  } state_t;

  typedef enum logic [1:0] {JOB_Z, JOB_SL, JOB_SLM, JOB_SR} job_t;

  state_t    state_r;
  job_t      job_r;
  seg_item_t it_r;

  // shared restoring divider, one quotient bit a cycle
  logic [7:0]  rem_r, den_r;
  logic [23:0] num_r, quo_r;
  logic [4:0]  cnt_r;
  logic        neg_r;
  logic [8:0]  rem2;
  logic        ge;
  logic signed [24:0] qs;

  logic [16:0]        z_r;
  logic signed [24:0] s_l_r, s_lm_r, s_r_r, tl_r, tr_r;
  logic [33:0]        z2_r;
  logic [50:0]        z3_r;
  logic signed [33:0] tld_r, trd_r;
  logic signed [28:0] h00_r, h10_r, h01_r, h11_r;
  logic signed [63:0] p0_r, p1_r, p2_r;
  logic [7:0]         res_r;
  logic [7:0]         level_r;
  logic               out_valid_r;

  logic [23:0]        j_num;
  logic [7:0]         j_den;
  logic               j_neg;
  logic signed [8:0]  j_dy, j_dx;
  logic signed [25:0] sum_l, sum_r;
  logic signed [52:0] z1s, z2s, z3s, h00, h10, h01, h11, half;
  logic signed [63:0] s;
  logic signed [63:0] v;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_level = level_r;

  // operands of the division selected by the job
  always_comb begin
    j_dy = '0;
    j_dx = '0;
    unique case (job_r)
      JOB_SL:  begin j_dy = it_r.dy_l;  j_dx = $signed({1'b0, it_r.d}); end
      JOB_SLM: begin j_dy = it_r.dy_lm; j_dx = it_r.dx_lm; end
      JOB_SR:  begin j_dy = it_r.dy_r;  j_dx = it_r.dx_r;  end
      default: ;
    endcase
    if (job_r == JOB_Z) begin
      j_num = {it_r.dxl, 16'h0};
      j_den = it_r.d;
      j_neg = 1'b0;
    end else begin
      j_num = {(j_dy < 0) ? 8'(-j_dy) : j_dy[7:0], 16'h0};
      j_den = (j_dx > 0) ? j_dx[7:0] : 8'h0;
      j_neg = (j_dy < 0);
    end
  end

  always_comb begin
    rem2 = {rem_r, num_r[23]};
    ge   = (rem2 >= {1'b0, den_r});
    qs   = (den_r == 8'h0) ? 25'sd0 :
           neg_r ? -$signed({1'b0, quo_r[22:0], ge}) : $signed({1'b0, quo_r[22:0], ge});
    sum_l = 26'(s_lm_r) + 26'(s_l_r);
    sum_r = 26'(s_l_r) + 26'(s_r_r);
    z1s  = 53'(z_r);
    z2s  = 53'(z2_r);
    z3s  = 53'(z3_r);
    half = 53'sd1 <<< 23;
    h00 = 2 * z3s - ((3 * z2s) <<< 16) + (53'sd1 <<< 48);
    h10 = z3s - ((2 * z2s) <<< 16) + (z1s <<< 32);
    h01 = -2 * z3s + ((3 * z2s) <<< 16);
    h11 = z3s - (z2s <<< 16);
    s   = (p0_r <<< 16) + p1_r + p2_r;
    v   = (s + (64'sd1 <<< 39)) >>> 40;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      job_r       <= JOB_Z;
    end else begin
      // output register: refilled from S_OUT, emptied by a pop transaction
      if (state_r == S_OUT && (!out_valid_r || out_pop)) out_valid_r <= 1'b1;
      else if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            it_r <= q_item;
            if (q_item.deg) begin
              res_r   <= q_item.yl;
              state_r <= S_OUT;
            end else begin
              job_r   <= JOB_Z;
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          rem_r   <= '0;
          num_r   <= j_num;
          den_r   <= j_den;
          neg_r   <= j_neg;
          quo_r   <= '0;
          cnt_r   <= 5'd23;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? 8'(rem2 - {1'b0, den_r}) : rem2[7:0];
          num_r <= {num_r[22:0], 1'b0};
          quo_r <= {quo_r[22:0], ge};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            unique case (job_r)
              JOB_Z: begin
                case (it_r.zsel)
                  ZS_LOW:  z_r <= 17'd0;
                  ZS_HIGH: z_r <= 17'h10000;
                  default: z_r <= {1'b0, qs[15:0]};
                endcase
                job_r   <= JOB_SL;
                state_r <= S_LOAD;
              end
              JOB_SL:  begin s_l_r  <= qs; job_r <= JOB_SLM; state_r <= S_LOAD; end
              JOB_SLM: begin s_lm_r <= qs; job_r <= JOB_SR;  state_r <= S_LOAD; end
              JOB_SR:  begin s_r_r  <= qs; state_r <= S_SQ; end
            endcase
          end
        end
        S_SQ: begin
          z2_r <= 34'(z_r) * 34'(z_r);
          // inner tangent: mean of slopes, truncated toward zero
          tl_r <= it_r.l_first ? s_l_r : 25'((sum_l + 26'(sum_l < 0)) >>> 1);
          tr_r <= it_r.r_last  ? s_l_r : 25'((sum_r + 26'(sum_r < 0)) >>> 1);
          state_r <= S_CUBE;
        end
        S_CUBE: begin
          z3_r  <= 51'(z2_r) * 51'(z_r);
          tld_r <= 34'(tl_r) * $signed({26'd0, it_r.d});
          trd_r <= 34'(tr_r) * $signed({26'd0, it_r.d});
          state_r <= S_BASIS;
        end
        S_BASIS: begin
          h00_r <= 29'((h00 + half) >>> 24);
          h10_r <= 29'((h10 + half) >>> 24);
          h01_r <= 29'((h01 + half) >>> 24);
          h11_r <= 29'((h11 + half) >>> 24);
          state_r <= S_PROD;
        end
        S_PROD: begin
          p0_r <= 64'(h00_r) * $signed({56'd0, it_r.yl}) +
                  64'(h01_r) * $signed({56'd0, it_r.yr});
          p1_r <= 64'(h10_r) * 64'(tld_r);
          p2_r <= 64'(h11_r) * 64'(trd_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (s < 0) res_r <= 8'd0;
          else if (v > 64'sd255) res_r <= 8'd255;
          else res_r <= v[7:0];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_pop) begin
            level_r <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
